@@ sv/cp4_pkg.sv @@
package cp4_pkg;

    localparam int ADDR_BITS = 20;
    localparam int PLANES    = 4;
    localparam int PTR_BITS  = $clog2(PLANES);
    localparam int GRP_BITS  = ADDR_BITS - 1;
    localparam int QTR_BITS  = ADDR_BITS - 2;

    localparam logic [ADDR_BITS-1:0] IMAGE_BYTES_RST = ADDR_BITS'(32000);
    localparam logic [2:0]           LAST_BIT        = 3'd7;

    typedef struct packed {
        logic [PLANES-1:0] pixel_index;
        logic              frame_start;
    } cp4_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] byte_address;
        logic [7:0]           plane_byte;
        logic                 last_of_group;
    } cp4_out_t;

endpackage

@@ sv/chunky_to_planar_4bpp_core.sv @@
// Chunky to planar converter, 4 bits per pixel.
//
// Input channel (s_valid/s_ready/s_data): one word per pixel, a 4-bit
// colour index plus a frame_start flag that restarts the group counters.
// Output channel (m_valid/m_ready/m_data): after every eighth pixel that
// fits in the frame, four words leave in plane order 0..3, each a plane
// byte with its destination address; last_of_group marks the plane 3 word.
// Config channel (cfg_valid/cfg_ready/cfg_data): image size in bytes,
// always ready, to be written while the block is idle.
//
// Throughput: one pixel per cycle. A group's four words are drained from a
// four-entry output buffer at one word per cycle, while the next group is
// already shifting in. Latency: the first word of a group is valid in the
// cycle after its eighth pixel is taken.
// If the receiver stalls, the buffer holds; s_ready is low while seven
// pixels of the next group are in and words are still waiting in the
// buffer, whether or not a pixel is offered.
// Reset (aresetn low, synchronous) clears counters and shift registers,
// empties the buffer and sets the image size back to 32000.
module chunky_to_planar_4bpp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cp4_pkg::cp4_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cp4_pkg::cp4_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cp4_pkg::ADDR_BITS-1:0] cfg_data
);
    import cp4_pkg::*;

    logic [ADDR_BITS-1:0] image_bytes_reg, image_bytes_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic [GRP_BITS-1:0]  group_reg, group_next;
    logic [7:0]           shift_reg [PLANES];
    logic [7:0]           shift_next [PLANES];
    logic                 busy_reg, busy_next;
    logic [PTR_BITS-1:0]  ptr_reg, ptr_next;
    logic [ADDR_BITS-1:0] addr_reg [PLANES];
    logic [ADDR_BITS-1:0] addr_next [PLANES];
    logic [7:0]           byte_reg [PLANES];
    logic [7:0]           byte_next [PLANES];

    logic                 s_accept, m_accept, full, group_done;
    logic [2:0]           bit_base;
    logic [GRP_BITS-1:0]  group_base;
    logic [7:0]           shift_base [PLANES];
    logic [GRP_BITS-1:0]  half;
    logic [QTR_BITS-1:0]  quarter;
    logic [ADDR_BITS-1:0] offs [PLANES];

    assign cfg_ready = 1'b1;
    assign s_ready   = (bit_cnt_reg != LAST_BIT) || !busy_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid && m_ready;

    assign half    = image_bytes_reg[ADDR_BITS-1:1];
    assign quarter = image_bytes_reg[ADDR_BITS-1:2];

    always_comb begin
        offs[0] = '0;
        offs[1] = ADDR_BITS'(quarter);
        offs[2] = ADDR_BITS'(half);
        offs[3] = ADDR_BITS'(quarter) + ADDR_BITS'(half);
    end

    // frame_start clears the counters before the pixel is taken
    always_comb begin
        bit_base   = s_data.frame_start ? 3'd0 : bit_cnt_reg;
        group_base = s_data.frame_start ? '0 : group_reg;
        for (int p = 0; p < PLANES; p++) begin
            shift_base[p] = s_data.frame_start ? 8'd0 : shift_reg[p];
        end
        full       = group_base >= GRP_BITS'(quarter);
        group_done = !full && (bit_base == LAST_BIT);
    end

    always_comb begin
        image_bytes_next = image_bytes_reg;
        bit_cnt_next     = bit_cnt_reg;
        group_next       = group_reg;
        busy_next        = busy_reg;
        ptr_next         = ptr_reg;
        for (int p = 0; p < PLANES; p++) begin
            shift_next[p] = shift_reg[p];
            addr_next[p]  = addr_reg[p];
            byte_next[p]  = byte_reg[p];
        end

        if (cfg_valid && cfg_ready) begin
            image_bytes_next = cfg_data;
        end

        if (m_accept) begin
            if (ptr_reg == PTR_BITS'(PLANES - 1)) begin
                busy_next = 1'b0;
                ptr_next  = '0;
            end else begin
                ptr_next = ptr_reg + 1'b1;
            end
        end

        if (s_accept) begin
            bit_cnt_next = bit_base;
            group_next   = group_base;
            for (int p = 0; p < PLANES; p++) begin
                shift_next[p] = shift_base[p];
            end
            if (!full) begin
                bit_cnt_next = bit_base + 3'd1;
                for (int p = 0; p < PLANES; p++) begin
                    shift_next[p] = {shift_base[p][6:0], s_data.pixel_index[p]};
                end
            end
            if (group_done) begin
                group_next = group_base + 1'b1;
                busy_next  = 1'b1;
                ptr_next   = '0;
                for (int p = 0; p < PLANES; p++) begin
                    addr_next[p] = ADDR_BITS'(group_base) + offs[p];
                    byte_next[p] = {shift_base[p][6:0], s_data.pixel_index[p]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_bytes_reg <= IMAGE_BYTES_RST;
            bit_cnt_reg     <= '0;
            group_reg       <= '0;
            busy_reg        <= 1'b0;
            ptr_reg         <= '0;
            for (int p = 0; p < PLANES; p++) begin
                shift_reg[p] <= '0;
            end
        end else begin
            image_bytes_reg <= image_bytes_next;
            bit_cnt_reg     <= bit_cnt_next;
            group_reg       <= group_next;
            busy_reg        <= busy_next;
            ptr_reg         <= ptr_next;
            for (int p = 0; p < PLANES; p++) begin
                shift_reg[p] <= shift_next[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int p = 0; p < PLANES; p++) begin
            addr_reg[p] <= addr_next[p];
            byte_reg[p] <= byte_next[p];
        end
    end

    assign m_valid = busy_reg;

    always_comb begin
        m_data.byte_address  = addr_reg[ptr_reg];
        m_data.plane_byte    = byte_reg[ptr_reg];
        m_data.last_of_group = (ptr_reg == PTR_BITS'(PLANES - 1));
    end

endmodule

@@ sv/cp4_checker.sv @@
module cp4_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cp4_pkg::cp4_out_t m_data
);
    import cp4_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // a group's words leave without gaps
    a_group_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_group |=> m_valid)
        else $error("gap inside a group of plane words");

    // input only stalls behind pending output words
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output buffer");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind chunky_to_planar_4bpp_core cp4_checker u_cp4_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_chunky_to_planar_4bpp_core.sv @@
module tb_chunky_to_planar_4bpp_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cp4_pkg::*;

    typedef logic [PLANES-1:0][ADDR_BITS-1:0] addr_set_t;
    typedef logic [PLANES-1:0][7:0]           byte_set_t;
    typedef cp4_out_t [PLANES-1:0]            group_t;

    // one pixel of the directed sequence, with an optional image size write before it
    typedef struct {
        bit                   cfg_en;
        logic [ADDR_BITS-1:0] cfg_val;
        cp4_in_t              item;
        bit                   typed;
        addr_set_t            want_addr;
        byte_set_t            want_byte;
    } dir_row_t;

    localparam int N_DIR     = 26;
    localparam int N_PHASES  = 10;
    localparam int HOLD_CYC  = 120;
    localparam int DRAIN_CYC = 8;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    cp4_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    cp4_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ADDR_BITS-1:0] cfg_data;

    // converter state as seen from outside
    logic [ADDR_BITS-1:0] img_bytes  = IMAGE_BYTES_RST;
    logic [2:0]           pix_in_grp = '0;
    byte_set_t            plane_sr   = '0;
    logic [GRP_BITS-1:0]  grp_idx    = '0;

    cp4_out_t plane_words_q [$];
    int       mismatches = 0;
    bit       hold_req   = 1'b0;
    bit       hold_done  = 1'b0;

    always #1 aclk = ~aclk;

    chunky_to_planar_4bpp_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void convert_pixel(input cp4_in_t px, output bit taken,
                                          output bit done, output group_t w);
        logic [ADDR_BITS-1:0] half;
        logic [ADDR_BITS-1:0] qtr;
        int unsigned          offs;
        half  = img_bytes >> 1;
        qtr   = half >> 1;
        taken = 1'b0;
        done  = 1'b0;
        w     = '0;
        if (px.frame_start) begin
            pix_in_grp = '0;
            grp_idx    = '0;
            plane_sr   = '0;
        end
        // frame full (or no room at all for a tiny image): pixel dropped
        if (grp_idx >= qtr) return;
        taken = 1'b1;
        for (int p = 0; p < PLANES; p++)
            plane_sr[p] = {plane_sr[p][6:0], px.pixel_index[p]};
        if (pix_in_grp != LAST_BIT) begin
            pix_in_grp = pix_in_grp + 3'd1;
            return;
        end
        pix_in_grp = '0;
        done       = 1'b1;
        for (int p = 0; p < PLANES; p++) begin
            case (p)
                0:       offs = 0;
                1:       offs = qtr;
                2:       offs = half;
                default: offs = qtr + half;
            endcase
            w[p].byte_address  = ADDR_BITS'(32'(grp_idx) + offs);
            w[p].plane_byte    = plane_sr[p];
            w[p].last_of_group = (p == PLANES - 1);
        end
        grp_idx = grp_idx + 1'b1;
    endfunction

    task automatic push_group(input group_t w);
        for (int p = 0; p < PLANES; p++)
            plane_words_q.push_back(w[p]);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(input cp4_in_t px, output bit taken, output bit done,
                              output group_t w);
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        convert_pixel(px, taken, done, w);
        @(negedge aclk);
    endtask

    task automatic pause_input(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic write_image_bytes(input logic [ADDR_BITS-1:0] val);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (plane_words_q.size() != 0) @(negedge aclk);
        // a partial group may still be shifting in, give it time to settle
        repeat (DRAIN_CYC) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        img_bytes = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_side
        int n;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(negedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : word_check
        cp4_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (plane_words_q.size() == 0) begin
                $error("unexpected output word: address %0d byte %h last %0b",
                       m_data.byte_address, m_data.plane_byte, m_data.last_of_group);
                mismatches++;
            end else begin
                want = plane_words_q.pop_front();
                if (m_data.byte_address !== want.byte_address) begin
                    $error("byte_address: expected %0d, got %0d",
                           want.byte_address, m_data.byte_address);
                    mismatches++;
                end
                if (m_data.plane_byte !== want.plane_byte) begin
                    $error("plane_byte: expected %h, got %h",
                           want.plane_byte, m_data.plane_byte);
                    mismatches++;
                end
                if (m_data.last_of_group !== want.last_of_group) begin
                    $error("last_of_group: expected %0b, got %0b",
                           want.last_of_group, m_data.last_of_group);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t             dir_tab [N_DIR];
        logic [ADDR_BITS-1:0] phase_cfg [N_PHASES];
        logic [ADDR_BITS-1:0] qtr;
        cp4_in_t              px;
        group_t               w;
        bit                   taken;
        bit                   done;
        int                   gap;
        int                   taken_n;
        int                   sent_n;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        dir_tab = '{
            // reset size 32000: offsets 0, 8000, 16000, 24000
            '{1'b0, 20'd0, {4'hF, 1'b1}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b1,
              {20'd24000, 20'd16000, 20'd8000, 20'd0},
              {8'hFF, 8'hFF, 8'hFF, 8'hFF}},
            // one bit walked across the planes: first pixel lands in bit 7
            '{1'b0, 20'd0, {4'h1, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h2, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h4, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h8, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h0, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h0, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h0, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h0, 1'b0}, 1'b1,
              {20'd24001, 20'd16001, 20'd8001, 20'd1},
              {8'h10, 8'h20, 8'h40, 8'h80}},
            // size 4: a single group per frame, offsets 0..3
            '{1'b1, 20'd4, {4'h5, 1'b1}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b0, '0, '0},
            '{1'b0, 20'd0, {4'h5, 1'b0}, 1'b1,
              {20'd3, 20'd2, 20'd1, 20'd0},
              {8'h00, 8'hFF, 8'h00, 8'hFF}},
            // frame already full: dropped
            '{1'b0, 20'd0, {4'hF, 1'b0}, 1'b0, '0, '0},
            // size below 4 leaves no group at all
            '{1'b1, 20'd3, {4'hF, 1'b1}, 1'b0, '0, '0}
        };
        phase_cfg = '{20'hFFFFF, 20'd32000, 20'd12, 20'd7, 20'd0,
                      20'd40, 20'hFFFFC, 20'd3, 20'd100, 20'd5};

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].cfg_en)
                write_image_bytes(dir_tab[i].cfg_val);
            send_pixel(dir_tab[i].item, taken, done, w);
            if (done && dir_tab[i].typed) begin
                for (int p = 0; p < PLANES; p++) begin
                    w[p].byte_address  = dir_tab[i].want_addr[p];
                    w[p].plane_byte    = dir_tab[i].want_byte[p];
                    w[p].last_of_group = (p == PLANES - 1);
                end
            end
            if (done)
                push_group(w);
            gap = pick_gap();
            if (gap > 0)
                pause_input(gap);
        end

        // random phases; counters carry over, so a size change can land mid-frame
        for (int i = 0; i < N_PHASES; i++) begin
            write_image_bytes(phase_cfg[i]);
            // receiver holds off first, then pixels keep coming until the input stalls
            if (i == 0) begin
                hold_req = 1'b1;
                wait (hold_done);
            end
            qtr     = img_bytes >> 2;
            taken_n = 0;
            sent_n  = 0;
            while (taken_n < 20 && sent_n < 40) begin
                px.pixel_index = 4'($urandom);
                if (qtr < 8)
                    px.frame_start = ($urandom_range(0, 5) == 0);
                else
                    px.frame_start = ($urandom_range(0, 39) == 0);
                send_pixel(px, taken, done, w);
                sent_n++;
                if (taken)
                    taken_n++;
                if (done)
                    push_group(w);
                gap = (i == 0 || i % 3 == 1) ? 0 : pick_gap();
                if (gap > 0)
                    pause_input(gap);
            end
        end

        s_valid <= 1'b0;
        while (plane_words_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && plane_words_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #200_000;
        $display("Verification failed");
        $finish;
    end

endmodule
